[sv/pls_pkg.sv]
`timescale 1ns / 1ps
// Package for the positional list store: operation and status codes,
// sequencer states and the result record. No dependencies.
package pls_pkg;

    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int FIDX_W    = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SWAP      = 3'd6,
        OP_SEARCH    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_DRAIN,
        S_PUT,
        S_SWAP_RD1,
        S_SWAP_RD2,
        S_SWAP_W1,
        S_SWAP_W2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] element_count;
        logic [FIDX_W-1:0]    found_index;
        logic                 found;
        t_status              status;
    } t_rsp;

endpackage

[sv/pls_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/pls_seq.sv]
`timescale 1ns / 1ps
// Sequencer of the positional list store: checks each operation, then walks
// the element RAM one read per cycle to shift or search, or reads and writes two slots to swap.
// Depends on pls_pkg and pls_ram.
module pls_seq
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_op                       i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [POS_W-1:0]          i_p1,
    input  logic [POS_W-1:0]          i_p2,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output t_rsp                      o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rd_valid, n_rd_valid;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [POS_W-1:0]      r_p1, n_p1;
    logic [POS_W-1:0]      r_p2, n_p2;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_last, n_last;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic [AW-1:0]         r_put_addr, n_put_addr;
    logic                  r_down, n_down;
    logic [DATA_WIDTH-1:0] r_hold, n_hold;
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_fidx, n_fidx;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [XW-1:0]         value_ext;
    logic                  is_search;
    logic                  is_insert;
    logic [AW-1:0]         shift_addr;
    logic                  match;

    assign value_ext  = XW'(i_value);
    assign is_search  = (r_op == OP_SEARCH);
    assign is_insert  = (r_op == OP_INS_FRONT) || (r_op == OP_INS_END) || (r_op == OP_INS_AT);
    // Insert moves each element up one slot, delete moves it down one slot.
    assign shift_addr = r_down ? (r_rd_addr + AW'(1)) : (r_rd_addr - AW'(1));
    assign match      = r_rd_valid && is_search && (ram_rdata == r_value);

    pls_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_valid <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_addr     <= n_addr;
        r_last     <= n_last;
        r_rd_addr  <= n_rd_addr;
        r_put_addr <= n_put_addr;
        r_down     <= n_down;
        r_hold     <= n_hold;
        r_status   <= n_status;
        r_found    <= n_found;
        r_fidx     <= n_fidx;
    end

    always_comb begin
        logic [PW-1:0] cnt_x;
        logic [PW-1:0] p1_x;
        logic [PW-1:0] p2_x;
        logic [AW-1:0] pos;

        n_state    = r_state;
        n_count    = r_count;
        n_rd_valid = r_rd_valid;
        n_op       = r_op;
        n_value    = r_value;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_addr     = r_addr;
        n_last     = r_last;
        n_rd_addr  = r_rd_addr;
        n_put_addr = r_put_addr;
        n_down     = r_down;
        n_hold     = r_hold;
        n_status   = r_status;
        n_found    = r_found;
        n_fidx     = r_fidx;

        ram_we      = 1'b0;
        ram_waddr   = shift_addr;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        o_in_ready  = 1'b0;
        o_rsp_valid = 1'b0;

        cnt_x = PW'(r_count);
        p1_x  = PW'(r_p1);
        p2_x  = PW'(r_p2);
        pos   = '0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op       = i_op;
                    n_value    = value_ext[DATA_WIDTH-1:0];
                    n_p1       = i_p1;
                    n_p2       = i_p2;
                    n_status   = ST_OK;
                    n_found    = 1'b0;
                    n_fidx     = '0;
                    n_rd_valid = 1'b0;
                    n_state    = S_CHECK;
                end
            end

            S_CHECK: begin
                n_state = S_DONE;
                unique case (r_op) inside
                    OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                        if (r_op == OP_INS_FRONT) begin
                            pos = '0;
                        end else if (r_op == OP_INS_END) begin
                            pos = AW'(r_count);
                        end else begin
                            pos = AW'(r_p1);
                        end
                        if ((r_op == OP_INS_AT) && (p1_x > cnt_x)) begin
                            n_status = ST_BOUND;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count    = r_count + CW'(1);
                            n_put_addr = pos;
                            n_down     = 1'b1;
                            if (PW'(pos) < cnt_x) begin
                                n_addr  = AW'(r_count - CW'(1));
                                n_last  = pos;
                                n_state = S_WALK;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
                        if (r_op == OP_DEL_FRONT) begin
                            pos = '0;
                        end else if (r_op == OP_DEL_END) begin
                            pos = AW'(r_count - CW'(1));
                        end else begin
                            pos = AW'(r_p1);
                        end
                        if ((r_op == OP_DEL_AT) && (p1_x >= cnt_x)) begin
                            n_status = ST_BOUND;
                        end else if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_down  = 1'b0;
                            if ((PW'(pos) + PW'(1)) < cnt_x) begin
                                n_addr  = pos + AW'(1);
                                n_last  = AW'(r_count - CW'(1));
                                n_state = S_WALK;
                            end
                        end
                    end
                    OP_SWAP: begin
                        if ((p1_x >= cnt_x) || (p2_x >= cnt_x)) begin
                            n_status = ST_BOUND;
                        end else if (r_p1 != r_p2) begin
                            n_state = S_SWAP_RD1;
                        end
                    end
                    default: begin
                        if (r_count != '0) begin
                            n_addr  = '0;
                            n_last  = AW'(r_count - CW'(1));
                            n_down  = 1'b0;
                            n_state = S_WALK;
                        end
                    end
                endcase
            end

            // One read issued per cycle; the data read in the previous cycle is
            // written one slot over, or compared against the target.
            S_WALK: begin
                if (r_rd_valid && !is_search) begin
                    ram_we = 1'b1;
                end
                if (match) begin
                    n_found    = 1'b1;
                    n_fidx     = r_rd_addr;
                    n_rd_valid = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_addr  = r_addr;
                    if (r_addr == r_last) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_addr = r_down ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                    end
                end
            end

            S_DRAIN: begin
                if (r_rd_valid && !is_search) begin
                    ram_we = 1'b1;
                end
                if (match) begin
                    n_found = 1'b1;
                    n_fidx  = r_rd_addr;
                end
                n_rd_valid = 1'b0;
                n_state    = is_insert ? S_PUT : S_DONE;
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_put_addr;
                ram_wdata = r_value;
                n_state   = S_DONE;
            end

            S_SWAP_RD1: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_p1);
                n_state   = S_SWAP_RD2;
            end

            S_SWAP_RD2: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_p2);
                n_hold    = ram_rdata;
                n_state   = S_SWAP_W1;
            end

            S_SWAP_W1: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_p1);
                ram_wdata = ram_rdata;
                n_state   = S_SWAP_W2;
            end

            S_SWAP_W2: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_p2);
                ram_wdata = r_hold;
                n_state   = S_DONE;
            end

            S_DONE: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.status        = r_status;
    assign o_rsp.found         = r_found;
    assign o_rsp.found_index   = FIDX_W'(r_fidx);
    assign o_rsp.element_count = CNT_OUT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (PW'(ram_waddr) < PW'(r_count)))
        else $error("RAM write outside the occupied list");

    a_count_changes_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> ($past(r_state) == S_CHECK))
        else $error("count changed outside the check step");

    a_found_is_ok_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.found) |-> ((o_rsp.status == ST_OK) && is_search))
        else $error("found flag on a non-search or failed result");

endmodule

[sv/positional_list_store.sv]
`timescale 1ns / 1ps
// Top level of the positional list store: stream ports, field unpacking and
// the result register. Depends on pls_pkg and pls_seq.
//
//  channel   | dir | tdata (low bit first)                          | tuser
//  ----------+-----+------------------------------------------------+-----------
//  s_axis    | in  | value[31:0], first_position, second_position   | operation
//  m_axis    | out | status, found, found_index, element_count      | -
//
// An item that moves nothing passes only the check step, a swap adds two reads
// and two writes, and a walk visits each of its elements in turn (one RAM read
// per cycle); an insert adds a step to write its value, so a full search or a
// front insert into a list one short of full takes the longest.
// Reset clears the count, so the list starts empty; no clearing pass runs.
// The result register frees the sequencer: the next item is taken while a
// result waits, and the sequencer holds a finished result when it is still full.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // value[31:0], first_position[38:32],
                                       // second_position[45:39], zero fill
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[1:0], found[2], found_index[8:3],
                                       // element_count[15:9]
);

    logic rsp_valid;
    logic rsp_ready;
    t_rsp rsp;
    logic r_out_valid;
    t_rsp r_out;

    pls_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (t_op'(s_axis_tuser)),
        .i_value     (s_axis_tdata[31:0]),
        .i_p1        (s_axis_tdata[38:32]),
        .i_p2        (s_axis_tdata[45:39]),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    assign rsp_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load a new result only when the previous transfer is done.
    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_ready) begin
            r_out <= rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.element_count, r_out.found_index,
                            r_out.found, r_out.status};

endmodule

[bench/pls_checker.sv]
`timescale 1ns / 1ps
// Result checker for the positional list store: watches both stream channels,
// keeps its own copy of the list to predict every result and compares them.
// Depends on pls_pkg.
module pls_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,    // value[31:0], first_position[38:32],
                                      // second_position[45:39], zero fill
    input  logic [2:0]  i_s_tuser,    // operation[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // status[1:0], found[2], found_index[8:3],
                                      // element_count[15:9]
    output int          o_mismatches,
    output int          o_pending,
    output logic [6:0]  o_fill
);

    logic [VALUE_W-1:0] list_mem [CAPACITY];
    int unsigned        list_len;
    t_rsp               expected_results [$];
    int                 mismatches;

    // Apply one operation to the shadow list and return the result it gives.
    function automatic t_rsp apply_list_op(t_op op, logic [VALUE_W-1:0] val,
                                           int unsigned p1, int unsigned p2);
        t_rsp               rsp;
        logic [VALUE_W-1:0] held;
        int unsigned        at;
        int unsigned        k;
        rsp        = '0;
        rsp.status = ST_OK;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                at = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? list_len : p1;
                if (op == OP_INS_AT && p1 > list_len) begin
                    rsp.status = ST_BOUND;
                end else if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (k = list_len; k > at; k--) list_mem[k] = list_mem[k-1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
                at = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_END) ? list_len - 1 : p1;
                // position bound wins over empty for delete at position
                if (op == OP_DEL_AT && p1 >= list_len) begin
                    rsp.status = ST_BOUND;
                end else if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    for (k = at; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            OP_SWAP: begin
                if (p1 >= list_len || p2 >= list_len) begin
                    rsp.status = ST_BOUND;
                end else begin
                    held         = list_mem[p1];
                    list_mem[p1] = list_mem[p2];
                    list_mem[p2] = held;
                end
            end
            default: begin
                for (k = 0; k < list_len; k++) begin
                    if (!rsp.found && list_mem[k] == val) begin
                        rsp.found       = 1'b1;
                        rsp.found_index = FIDX_W'(k);
                    end
                end
            end
        endcase
        rsp.element_count = CNT_OUT_W'(list_len);
        return rsp;
    endfunction

    task automatic note_mismatch(string field, int exp_val, int act_val);
        if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
                     exp_val, act_val);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        t_rsp act_rsp;
        if (!i_rst_n) begin
            list_len   = 0;
            mismatches = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_list_op(t_op'(i_s_tuser), i_s_tdata[31:0],
                                                         i_s_tdata[38:32], i_s_tdata[45:39]));
            if (i_m_tvalid && i_m_tready) begin
                act_rsp = t_rsp'(i_m_tdata);
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result, element_count", -1,
                                  act_rsp.element_count);
                end else begin
                    exp_rsp = expected_results.pop_front();
                    if (act_rsp.status != exp_rsp.status)
                        note_mismatch("status", exp_rsp.status, act_rsp.status);
                    if (act_rsp.found != exp_rsp.found)
                        note_mismatch("found", exp_rsp.found, act_rsp.found);
                    if (act_rsp.found_index != exp_rsp.found_index)
                        note_mismatch("found_index", exp_rsp.found_index,
                                      act_rsp.found_index);
                    if (act_rsp.element_count != exp_rsp.element_count)
                        note_mismatch("element_count", exp_rsp.element_count,
                                      act_rsp.element_count);
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_results.size();
        o_fill       <= 7'(list_len);
    end

endmodule

[bench/positional_list_store_test.sv]
`timescale 1ns / 1ps
// Testbench top for the positional list store: clock, reset, stimulus and
// verdict. Depends on pls_pkg, positional_list_store and pls_checker.
module positional_list_store_test;
    import pls_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int RANDOM_ITEMS    = 400;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int SETTLE_CYCLES   = CAPACITY + 24;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AFTER  = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // value[31:0], first_position[38:32],
                                      // second_position[45:39], zero fill
    logic [2:0]  s_axis_tuser  = '0;  // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[1:0], found[2], found_index[8:3],
                                      // element_count[15:9]

    int          mismatches;
    int          pending;
    logic [6:0]  fill;
    int unsigned burst_left   = 0;
    bit          hold_off_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    positional_list_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pls_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_fill       (fill)
    );

    // Offer one item in bursts with random gaps; return once it is transferred.
    task automatic offer_item(t_op op, logic [31:0] val, logic [6:0] p1, logic [6:0] p2);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, p2, p1, val};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_position(logic [6:0] len);
        if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, len));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        // a small pool makes duplicates and search hits common
        if (r < 45) return $urandom_range(0, 7) - 32'd4;
        if (r < 50) return (r[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    initial begin : stimulus
        bit          growing;
        int unsigned extra;
        int unsigned r;
        t_op         op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list
        offer_item(OP_DEL_FRONT, 32'd0, 7'd0, 7'd0);
        offer_item(OP_DEL_END, 32'd0, 7'd0, 7'd0);
        offer_item(OP_DEL_AT, 32'd0, 7'd0, 7'd0);        // bound beats empty
        offer_item(OP_SWAP, 32'd0, 7'd0, 7'd0);
        offer_item(OP_SEARCH, 32'd0, 7'd0, 7'd0);
        offer_item(OP_INS_AT, 32'd9, 7'd1, 7'd0);        // beyond count
        // fill with extremes
        offer_item(OP_INS_AT, 32'h7FFF_FFFF, 7'd0, 7'd0);
        offer_item(OP_INS_FRONT, 32'h8000_0000, 7'd0, 7'd0);
        offer_item(OP_INS_END, 32'hFFFF_FFFF, 7'd0, 7'd0);
        offer_item(OP_INS_AT, 32'd0, 7'd3, 7'd0);        // position equal to count
        offer_item(OP_SEARCH, 32'h8000_0000, 7'd0, 7'd0);
        offer_item(OP_SEARCH, 32'd0, 7'd0, 7'd0);
        offer_item(OP_SEARCH, 32'd5, 7'd0, 7'd0);
        offer_item(OP_SWAP, 32'd0, 7'd0, 7'd3);
        offer_item(OP_SWAP, 32'd0, 7'd2, 7'd2);          // with itself
        offer_item(OP_SWAP, 32'd0, 7'd1, 7'd4);
        offer_item(OP_SWAP, 32'd0, 7'd127, 7'd127);
        offer_item(OP_INS_AT, 32'h5555_AAAA, 7'd127, 7'd0);
        offer_item(OP_DEL_AT, 32'd0, 7'd127, 7'd0);
        offer_item(OP_DEL_AT, 32'd0, 7'd1, 7'd0);
        offer_item(OP_DEL_FRONT, 32'd0, 7'd0, 7'd0);
        offer_item(OP_DEL_END, 32'd0, 7'd0, 7'd0);
        offer_item(OP_DEL_AT, 32'd0, 7'd0, 7'd0);
        offer_item(OP_INS_END, 32'hA5A5_5A5A, 7'd0, 7'd0);

        // alternate between filling to capacity and draining to empty
        growing = 1'b1;
        extra   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (growing && fill >= CAPACITY) extra++;
            if (!growing && fill == 0) extra++;
            if (extra > 5) begin
                growing = !growing;
                extra   = 0;
            end
            r = $urandom_range(0, 99);
            if (r < (growing ? 78 : 12))
                op = t_op'($urandom_range(OP_INS_FRONT, OP_INS_AT));
            else if (r < (growing ? 86 : 22))
                op = OP_SEARCH;
            else if (r < (growing ? 93 : 30))
                op = OP_SWAP;
            else
                op = t_op'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
            if (op == OP_SEARCH && $urandom_range(0, 1) == 1)
                offer_item(op, $urandom_range(0, 7) - 32'd4, pick_position(fill),
                           pick_position(fill));
            else
                offer_item(op, pick_value(), pick_position(fill), pick_position(fill));
            if (n == HOLD_OFF_AFTER) hold_off_req <= 1'b1;
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: ready runs and stalls of random length, one long hold-off.
    initial begin : sink
        int unsigned run_len;
        int unsigned stall_len;
        bit          hold_off_done;
        hold_off_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (stall_len != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
